/* hdl/tmma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_pkg
// Operation codes, configuration indexes, shared types and the saturating add
// of the tile multiply-accumulate engine.
// ----------------------------------------------------------------------------
package tmma_pkg;

    localparam int DIM_W   = 4;
    localparam int CFG_I_W = 2;

    localparam logic [2:0] OP_WRITE_A = 3'd0;
    localparam logic [2:0] OP_WRITE_B = 3'd1;
    localparam logic [2:0] OP_CLEAR_C = 3'd2;
    localparam logic [2:0] OP_ACCUM   = 3'd3;
    localparam logic [2:0] OP_READ_C  = 3'd4;

    localparam logic [CFG_I_W-1:0] CFG_A_ROWS     = 2'd0;
    localparam logic [CFG_I_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_I_W-1:0] CFG_B_COLS     = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

    // effective tile dimensions, already clamped to the tile size
    typedef struct packed {
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nk;
        logic [DIM_W-1:0] nc;
    } t_dims;

    typedef struct packed {
        logic load;   // operand words sit at the memory outputs
        logic clr;    // restart the dot product
    } t_mac_ctl;

    typedef struct packed {
        logic busy;   // a product is still on its way into the dot sum
    } t_mac_stat;

    function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] s;
        s = x + y;
        if ((x[63] == y[63]) && (s[63] != x[63])) begin
            return x[63] ? SAT_NEG : SAT_POS;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

/* hdl/tmma_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_ram
// Single-port synchronous tile memory with a registered read word.
// ----------------------------------------------------------------------------
module tmma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // read word holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hdl/tmma_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_mac
// Multiply-accumulate datapath: registered Q32.32 product of Q16.16 words,
// saturating dot sum, and its saturating add into the accumulator word.
// ----------------------------------------------------------------------------
module tmma_mac
    import tmma_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_mac_ctl    i_ctl,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [63:0] i_acc,
    output t_mac_stat        o_stat,
    output logic [63:0]      o_sum
);

    logic signed [63:0] w_prod;
    logic        [63:0] r_prod;
    logic               r_prod_v;
    logic        [63:0] r_dot;

    assign w_prod = 64'($signed(i_a)) * 64'($signed(i_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= w_prod;
        end
        if (i_ctl.clr) begin
            r_dot <= '0;
        end else if (r_prod_v) begin
            r_dot <= sat_add(r_dot, r_prod);
        end
    end

    assign o_stat.busy = r_prod_v;
    assign o_sum       = sat_add(i_acc, r_dot);

endmodule
`default_nettype wire

/* hdl/tmma_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_seq
// Sequencer: decodes input words, drives the three tile memories, runs the
// clearing sweeps and walks the multiply-accumulate over the tile.
// ----------------------------------------------------------------------------
module tmma_seq
    import tmma_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire t_dims                                  i_dims,
    input  wire logic                                   i_in_valid,
    input  wire logic                                   i_hold,
    input  wire logic [2:0]                             i_operation,
    input  wire logic [2:0]                             i_row_index,
    input  wire logic [2:0]                             i_col_index,
    input  wire t_mac_stat                              i_mac_stat,
    output logic                                        o_in_stall,
    output logic                                        o_fill_zero,
    output logic                                        o_a_we,
    output logic                                        o_a_re,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          o_a_addr,
    output logic                                        o_b_we,
    output logic                                        o_b_re,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          o_b_addr,
    output logic                                        o_c_we,
    output logic                                        o_c_re,
    output logic                                        o_c_wsum,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          o_c_addr,
    output t_mac_ctl                                    o_mac_ctl
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    logic [DIM_W-1:0] r_i, n_i;
    logic [DIM_W-1:0] r_j, n_j;
    logic [DIM_W-1:0] r_k, n_k;
    logic             r_rd_v;
    logic [DIM_W-1:0] w_row, w_col;

    function automatic logic [AW-1:0] f_addr(input logic [DIM_W-1:0] r,
                                              input logic [DIM_W-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    assign w_row = {1'b0, i_row_index};
    assign w_col = {1'b0, i_col_index};

    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        n_i            = r_i;
        n_j            = r_j;
        n_k            = r_k;
        o_in_stall     = 1'b1;
        o_fill_zero    = 1'b0;
        o_a_we         = 1'b0;
        o_a_re         = 1'b0;
        o_b_we         = 1'b0;
        o_b_re         = 1'b0;
        o_c_we         = 1'b0;
        o_c_re         = 1'b0;
        o_c_wsum       = 1'b0;
        o_a_addr       = f_addr(w_row, w_col);
        o_b_addr       = f_addr(w_row, w_col);
        o_c_addr       = f_addr(w_row, w_col);
        o_mac_ctl.clr  = 1'b0;
        o_mac_ctl.load = r_rd_v;
        case (r_state)
            S_INIT: begin
                o_fill_zero = 1'b1;
                o_a_we      = 1'b1;
                o_b_we      = 1'b1;
                o_c_we      = 1'b1;
                o_a_addr    = r_addr;
                o_b_addr    = r_addr;
                o_c_addr    = r_addr;
                n_addr      = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end
            end
            S_IDLE: begin
                o_in_stall = i_hold;
                if (i_in_valid && !i_hold) begin
                    case (i_operation)
                        OP_WRITE_A: begin
                            o_a_we = (w_row < i_dims.nr) && (w_col < i_dims.nk);
                        end
                        OP_WRITE_B: begin
                            o_b_we = (w_row < i_dims.nk) && (w_col < i_dims.nc);
                        end
                        OP_CLEAR_C: begin
                            n_state = S_CLEAR;
                            n_addr  = '0;
                        end
                        OP_ACCUM: begin
                            // an empty dimension leaves the accumulators as they are
                            if ((i_dims.nr != '0) && (i_dims.nk != '0) &&
                                (i_dims.nc != '0)) begin
                                n_state       = S_MAC;
                                n_i           = '0;
                                n_j           = '0;
                                n_k           = '0;
                                o_mac_ctl.clr = 1'b1;
                            end
                        end
                        OP_READ_C: begin
                            o_c_re = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_c_we   = 1'b1;
                o_c_addr = r_addr;
                n_addr   = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end
            end
            S_MAC: begin
                o_a_re   = 1'b1;
                o_b_re   = 1'b1;
                o_a_addr = f_addr(r_i, r_k);
                o_b_addr = f_addr(r_k, r_j);
                // fetch the accumulator word at the start of each element
                o_c_re   = (r_k == '0);
                o_c_addr = f_addr(r_i, r_j);
                n_k      = r_k + 1'b1;
                if (r_k == i_dims.nk - 1'b1) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_c_addr = f_addr(r_i, r_j);
                if (!r_rd_v && !i_mac_stat.busy) begin
                    o_c_we        = 1'b1;
                    o_c_wsum      = 1'b1;
                    o_mac_ctl.clr = 1'b1;
                    n_state       = S_MAC;
                    n_j           = r_j + 1'b1;
                    if (r_j == i_dims.nc - 1'b1) begin
                        n_j = '0;
                        n_i = r_i + 1'b1;
                        if (r_i == i_dims.nr - 1'b1) begin
                            n_i     = '0;
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_rd_v  <= o_a_re;
        end
    end

endmodule
`default_nettype wire

/* hdl/tile_matrix_multiply_accumulate.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tile_matrix_multiply_accumulate
// Tile engine for C += A*B with Q16.16 elements and saturating Q32.32 sums.
// ----------------------------------------------------------------------------
// After reset the block clears all three tile memories in one pass and holds
// off input words until done. Element writes of A or B, reads of C and unused
// operation codes leave the block idle; a read result moves from the
// accumulator read word through the pending register into the output register,
// and the next word is taken while that result waits, unless a pending read
// cannot move on past a stalled output. A clear of C sweeps the accumulator
// memory one entry a cycle. An accumulate walks the tile through the single
// read port of each memory and one multiplier, and does nothing when a
// dimension is zero. Dimension registers above MAX_DIM act as MAX_DIM.
module tile_matrix_multiply_accumulate
    import tmma_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_I_W-1:0]  i_cfg_index,
    input  wire logic [DIM_W-1:0]    i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [2:0]          i_operation,
    input  wire logic [2:0]          i_row_index,
    input  wire logic [2:0]          i_col_index,
    input  wire logic signed [31:0]  i_element_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [2:0]               o_out_row,
    output logic [2:0]               o_out_col,
    output logic signed [63:0]       o_sum_value
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [DIM_W-1:0] r_a_rows, r_inner_size, r_b_cols;
    t_dims            w_dims;
    t_mac_ctl         w_mac_ctl;
    t_mac_stat        w_mac_stat;

    logic             w_fill_zero;
    logic             w_a_we, w_a_re, w_b_we, w_b_re, w_c_we, w_c_re, w_c_wsum;
    logic [AW-1:0]    w_a_addr, w_b_addr, w_c_addr;
    logic [31:0]      w_ab_wdata, w_a_rdata, w_b_rdata;
    logic [63:0]      w_c_wdata, w_c_rdata, w_sum;

    logic             r_pend;
    logic [2:0]       r_pend_row, r_pend_col;
    logic             r_pend_in;
    logic             w_pend_move;
    logic             w_hold;
    logic             w_in_take;

    logic             r_out_valid;
    logic [2:0]       r_out_row, r_out_col;
    logic [63:0]      r_out_sum;

    function automatic logic [DIM_W-1:0] f_eff(input logic [DIM_W-1:0] v);
        return (int'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows     <= DIM_RESET;
            r_inner_size <= DIM_RESET;
            r_b_cols     <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_A_ROWS:     r_a_rows     <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_B_COLS:     r_b_cols     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_dims.nr = f_eff(r_a_rows);
    assign w_dims.nk = f_eff(r_inner_size);
    assign w_dims.nc = f_eff(r_b_cols);

    tmma_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (w_dims),
        .i_in_valid  (i_in_valid),
        .i_hold      (w_hold),
        .i_operation (i_operation),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_mac_stat  (w_mac_stat),
        .o_in_stall  (o_in_stall),
        .o_fill_zero (w_fill_zero),
        .o_a_we      (w_a_we),
        .o_a_re      (w_a_re),
        .o_a_addr    (w_a_addr),
        .o_b_we      (w_b_we),
        .o_b_re      (w_b_re),
        .o_b_addr    (w_b_addr),
        .o_c_we      (w_c_we),
        .o_c_re      (w_c_re),
        .o_c_wsum    (w_c_wsum),
        .o_c_addr    (w_c_addr),
        .o_mac_ctl   (w_mac_ctl)
    );

    assign w_ab_wdata = w_fill_zero ? '0 : 32'(i_element_value);
    assign w_c_wdata  = w_c_wsum ? w_sum : '0;

    tmma_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_re    (w_a_re),
        .i_addr  (w_a_addr),
        .i_wdata (w_ab_wdata),
        .o_rdata (w_a_rdata)
    );

    tmma_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_re    (w_b_re),
        .i_addr  (w_b_addr),
        .i_wdata (w_ab_wdata),
        .o_rdata (w_b_rdata)
    );

    tmma_ram #(.WIDTH(64), .DEPTH(DEPTH), .AW(AW)) u_c_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_re    (w_c_re),
        .i_addr  (w_c_addr),
        .i_wdata (w_c_wdata),
        .o_rdata (w_c_rdata)
    );

    tmma_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_a_rdata),
        .i_b     (w_b_rdata),
        .i_acc   (w_c_rdata),
        .o_stat  (w_mac_stat),
        .o_sum   (w_sum)
    );

    // pending read waits on the accumulator read word, then moves to the output
    assign w_pend_move = r_pend && (!r_out_valid || !i_out_stall);
    assign w_hold      = r_pend && !w_pend_move;
    assign w_in_take   = i_in_valid && !o_in_stall && (i_operation == OP_READ_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_pend <= 1'b1;
            end else if (w_pend_move) begin
                r_pend <= 1'b0;
            end
            if (w_pend_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_pend_row <= i_row_index;
            r_pend_col <= i_col_index;
            r_pend_in  <= ({1'b0, i_row_index} < w_dims.nr) &&
                          ({1'b0, i_col_index} < w_dims.nc);
        end
        if (w_pend_move) begin
            r_out_row <= r_pend_row;
            r_out_col <= r_pend_col;
            r_out_sum <= r_pend_in ? w_c_rdata : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_sum_value = $signed(r_out_sum);

endmodule
`default_nettype wire

/* hdl/tmma_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_checker
// Port-level checks of the tile engine, bound to the top level.
// ----------------------------------------------------------------------------
module tmma_checker
    import tmma_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_cfg_we,
    input wire logic [CFG_I_W-1:0]  i_cfg_index,
    input wire logic [DIM_W-1:0]    i_cfg_data,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic [2:0]          i_operation,
    input wire logic [2:0]          i_row_index,
    input wire logic [2:0]          i_col_index,
    input wire logic signed [31:0]  i_element_value,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire logic [2:0]          o_out_row,
    input wire logic [2:0]          o_out_col,
    input wire logic signed [63:0]  o_sum_value
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // a waiting result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_sum_value) && $stable(o_out_row) && $stable(o_out_col))
        else $error("result payload changed while stalled");

    // reset starts the clearing pass, no input taken right after
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

    // a clear of the accumulators occupies the block for its sweep
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_operation == OP_CLEAR_C) |=> o_in_stall)
        else $error("input taken during accumulator clear");

endmodule

bind tile_matrix_multiply_accumulate tmma_checker u_tmma_checker (.*);
`default_nettype wire
